// ===== design/tpfl_pkg.sv =====
// Shared types and constants of the two-region page frame allocator.
// Holds the request, region and status codes and the fixed field widths.
// Depends on nothing.
package tpfl_pkg;

   localparam int FRAME_W = 20;
   localparam int COUNT_W = 17;

   // Request kinds.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Region select.
   localparam logic REGION_USER   = 1'b0;
   localparam logic REGION_KERNEL = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

endpackage

// ===== design/two_region_page_free_list_allocator_core.sv =====
// Top level of the two-region page frame allocator: free lists in two
// synchronous memories with one write and one read port each, head and count registers, sequencer.
// Depends on tpfl_pkg.
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  ----------------------
//   request   req_type, req_region, req_page_frame    start && !busy
//   response  rsp_alloc_frame, rsp_status,            rsp_valid, one cycle,
//             rsp_kernel_free, rsp_user_free          cannot be held off
//
// Each request runs in two steps: the accept edge reads the next pointer of
// the head from memory, the following edge updates the list and registers
// the result, and busy is low again for the cycle after. The block takes no
// new request while one is in execution, as the next pointer comes through
// the registered memory read. After reset a sweep writes the ascending links
// into both memories, with busy high. The response side has no stall.
module two_region_page_free_list_allocator_core
   import tpfl_pkg::*;
#(
   parameter int BASE_FRAME   = 524288,
   parameter int KERNEL_PAGES = 1024,
   parameter int USER_PAGES   = 16384
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic               req_region,
   input  logic [FRAME_W-1:0] req_page_frame,
   output logic               rsp_valid,
   output logic [FRAME_W-1:0] rsp_alloc_frame,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_kernel_free,
   output logic [COUNT_W-1:0] rsp_user_free
);

   localparam int KIW = (KERNEL_PAGES > 1) ? $clog2(KERNEL_PAGES) : 1;
   localparam int UIW = (USER_PAGES > 1) ? $clog2(USER_PAGES) : 1;
   localparam int KPW = $clog2(KERNEL_PAGES + 1);
   localparam int UPW = $clog2(USER_PAGES + 1);
   localparam int MAXP = (KERNEL_PAGES > USER_PAGES) ? KERNEL_PAGES : USER_PAGES;
   localparam int IW = $clog2(MAXP + 1);
   localparam int XW = FRAME_W + 2;

   localparam logic [KPW-1:0] KSIZE = KPW'(KERNEL_PAGES);
   localparam logic [UPW-1:0] USIZE = UPW'(USER_PAGES);
   localparam logic [XW-1:0]  KFIRST = XW'(BASE_FRAME);
   localparam logic [XW-1:0]  KEND = XW'(BASE_FRAME + KERNEL_PAGES);
   localparam logic [XW-1:0]  UFIRST = XW'(BASE_FRAME + KERNEL_PAGES);
   localparam logic [XW-1:0]  UEND = XW'(BASE_FRAME + KERNEL_PAGES + USER_PAGES);
   localparam logic [IW-1:0]  INIT_LAST = IW'(MAXP - 1);

   typedef enum logic [2:0] {
      ST_INIT = 3'b001,
      ST_IDLE = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] init_cnt_ff, init_cnt_in;
   logic [KPW-1:0] khead_ff, khead_in, kcount_ff, kcount_in;
   logic [UPW-1:0] uhead_ff, uhead_in, ucount_ff, ucount_in;
   logic type_ff, region_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_kfree_ff, rsp_ufree_ff;

   // Free-list memories and their ports.
   logic [KPW-1:0] kmem [KERNEL_PAGES];
   logic [UPW-1:0] umem [USER_PAGES];
   logic           kwe, uwe;
   logic [KIW-1:0] kwa;
   logic [UIW-1:0] uwa;
   logic [KPW-1:0] kwd, krd_ff;
   logic [UPW-1:0] uwd, urd_ff;

   logic           accept;
   logic [XW-1:0]  frame_x, koff, uoff;
   logic           kin_range, uin_range;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign frame_x = {2'b00, frame_ff};
   assign koff    = frame_x - KFIRST;
   assign uoff    = frame_x - UFIRST;
   assign kin_range = (frame_x >= KFIRST) && (frame_x < KEND);
   assign uin_range = (frame_x >= UFIRST) && (frame_x < UEND);

   // The read is issued every cycle at the current head, so the beat accepted
   // at an edge finds next[head] in the read register on the following cycle.
   always_ff @(posedge clock) begin
      if (kwe) begin
         kmem[kwa] <= kwd;
      end
      krd_ff <= kmem[khead_ff[KIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (uwe) begin
         umem[uwa] <= uwd;
      end
      urd_ff <= umem[uhead_ff[UIW-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      khead_in      = khead_ff;
      kcount_in     = kcount_ff;
      uhead_in      = uhead_ff;
      ucount_in     = ucount_ff;
      rsp_valid_in  = 1'b0;
      rsp_frame_in  = '0;
      rsp_status_in = STATUS_OK;
      kwe = 1'b0;
      kwa = init_cnt_ff[KIW-1:0];
      kwd = KPW'(init_cnt_ff) + KPW'(1);
      uwe = 1'b0;
      uwa = init_cnt_ff[UIW-1:0];
      uwd = UPW'(init_cnt_ff) + UPW'(1);
      unique case (state_ff)
         ST_INIT: begin
            kwe = (init_cnt_ff < IW'(KERNEL_PAGES));
            uwe = (init_cnt_ff < IW'(USER_PAGES));
            init_cnt_in = init_cnt_ff + IW'(1);
            if (init_cnt_ff == INIT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (type_ff == REQ_ALLOC) begin
               if (region_ff == REGION_KERNEL) begin
                  if (kcount_ff == '0 || khead_ff >= KSIZE) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     rsp_frame_in = FRAME_W'(KFIRST + XW'(khead_ff));
                     khead_in     = krd_ff;
                     kcount_in    = kcount_ff - KPW'(1);
                  end
               end else begin
                  if (ucount_ff == '0 || uhead_ff >= USIZE) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     rsp_frame_in = FRAME_W'(UFIRST + XW'(uhead_ff));
                     uhead_in     = urd_ff;
                     ucount_in    = ucount_ff - UPW'(1);
                  end
               end
            end else begin
               if (region_ff == REGION_KERNEL) begin
                  if (!kin_range) begin
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     kwe      = 1'b1;
                     kwa      = koff[KIW-1:0];
                     kwd      = khead_ff;
                     khead_in = koff[KPW-1:0];
                     if (kcount_ff < KSIZE) begin
                        kcount_in = kcount_ff + KPW'(1);
                     end
                  end
               end else begin
                  if (!uin_range) begin
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     uwe      = 1'b1;
                     uwa      = uoff[UIW-1:0];
                     uwd      = uhead_ff;
                     uhead_in = uoff[UPW-1:0];
                     if (ucount_ff < USIZE) begin
                        ucount_in = ucount_ff + UPW'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         khead_ff     <= '0;
         kcount_ff    <= KSIZE;
         uhead_ff     <= '0;
         ucount_ff    <= USIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         khead_ff     <= khead_in;
         kcount_ff    <= kcount_in;
         uhead_ff     <= uhead_in;
         ucount_ff    <= ucount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff   <= req_type;
         region_ff <= req_region;
         frame_ff  <= req_page_frame;
      end
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kfree_ff  <= COUNT_W'(kcount_in);
      rsp_ufree_ff  <= COUNT_W'(ucount_in);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_frame = rsp_frame_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_kernel_free = rsp_kfree_ff;
   assign rsp_user_free   = rsp_ufree_ff;

   // A beat that is accepted keeps the block busy for its execution cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && state_ff == ST_EXEC))
      else $error("accepted request did not enter execution");

   // Each accepted request is answered by a response strobe, seen with busy low again.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 (rsp_valid && !busy))
      else $error("response missing after accepted request");

   a_no_double_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // A failed request grants no frame and leaves the counts as they were.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && rsp_status_in != STATUS_OK)
         |=> (rsp_alloc_frame == '0 && $stable(kcount_ff) && $stable(ucount_ff)))
      else $error("failed request changed state or granted a frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (kcount_ff <= KSIZE) && (ucount_ff <= USIZE))
      else $error("free count above region size");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the two-region page frame allocator core: random and directed
// allocate and free beats checked against a free-list predictor held in a
// scoreboard class. Depends on tpfl_pkg and two_region_page_free_list_allocator_core.
module tb;
   import tpfl_pkg::*;

   localparam int BASE_FRAME   = 524288;
   localparam int KERNEL_PAGES = 1024;
   localparam int USER_PAGES   = 16384;
   localparam int KERN_W     = $clog2(KERNEL_PAGES + 1);
   localparam int USER_W     = $clog2(USER_PAGES + 1);
   localparam int KERN_FIRST = BASE_FRAME;
   localparam int USER_FIRST = BASE_FRAME + KERNEL_PAGES;
   localparam int USER_END   = USER_FIRST + USER_PAGES;
   localparam int ITEM_GOAL  = 1620;

   typedef struct {
      logic [FRAME_W-1:0] frame;
      status_type         status;
      logic [COUNT_W-1:0] kern_free;
      logic [COUNT_W-1:0] user_free;
   } page_result_type;

   class page_alloc_scoreboard;
      logic [KERN_W-1:0]  kern_link [KERNEL_PAGES];
      logic [USER_W-1:0]  user_link [USER_PAGES];
      logic [KERN_W-1:0]  kern_head, kern_count;
      logic [USER_W-1:0]  user_head, user_count;
      logic [FRAME_W-1:0] kern_held[$], user_held[$];
      page_result_type    pending[$];
      int                 errors;

      function new();
         for (int i = 0; i < KERNEL_PAGES; i++) kern_link[i] = KERN_W'(i + 1);
         for (int i = 0; i < USER_PAGES; i++) user_link[i] = USER_W'(i + 1);
         kern_head  = '0;
         user_head  = '0;
         kern_count = KERN_W'(KERNEL_PAGES);
         user_count = USER_W'(USER_PAGES);
         errors     = 0;
      endfunction

      function status_type pop_page(logic rgn, output logic [FRAME_W-1:0] frame);
         frame = '0;
         if (rgn == REGION_KERNEL) begin
            if (kern_count == 0 || kern_head >= KERNEL_PAGES) return STATUS_EMPTY;
            frame      = FRAME_W'(KERN_FIRST + kern_head);
            kern_head  = kern_link[kern_head];
            kern_count = kern_count - 1'b1;
         end else begin
            if (user_count == 0 || user_head >= USER_PAGES) return STATUS_EMPTY;
            frame      = FRAME_W'(USER_FIRST + user_head);
            user_head  = user_link[user_head];
            user_count = user_count - 1'b1;
         end
         return STATUS_OK;
      endfunction

      // Double frees are pushed again and the count stops at the region size.
      function status_type push_page(logic rgn, logic [FRAME_W-1:0] frame);
         int unsigned first, size, offset;
         first = (rgn == REGION_KERNEL) ? KERN_FIRST : USER_FIRST;
         size  = (rgn == REGION_KERNEL) ? KERNEL_PAGES : USER_PAGES;
         if (frame < first || frame - first >= size) return STATUS_RANGE;
         offset = frame - first;
         if (rgn == REGION_KERNEL) begin
            kern_link[offset] = kern_head;
            kern_head = KERN_W'(offset);
            if (kern_count < KERNEL_PAGES) kern_count = kern_count + 1'b1;
         end else begin
            user_link[offset] = user_head;
            user_head = USER_W'(offset);
            if (user_count < USER_PAGES) user_count = user_count + 1'b1;
         end
         return STATUS_OK;
      endfunction

      function void note_request(logic kind, logic rgn, logic [FRAME_W-1:0] frame);
         page_result_type    want;
         logic [FRAME_W-1:0] granted;
         if (kind == REQ_ALLOC) begin
            want.status = pop_page(rgn, granted);
            if (want.status == STATUS_OK) begin
               if (rgn == REGION_KERNEL) kern_held.push_back(granted);
               else user_held.push_back(granted);
            end
         end else begin
            granted     = '0;
            want.status = push_page(rgn, frame);
         end
         want.frame     = granted;
         want.kern_free = COUNT_W'(kern_count);
         want.user_free = COUNT_W'(user_count);
         pending.push_back(want);
      endfunction

      // Hands back a frame that is currently out on loan, for a clean free.
      function bit take_held(logic rgn, output logic [FRAME_W-1:0] frame);
         int idx;
         frame = '0;
         if (rgn == REGION_KERNEL) begin
            if (kern_held.size() == 0) return 1'b0;
            idx   = $urandom_range(kern_held.size() - 1);
            frame = kern_held[idx];
            kern_held.delete(idx);
         end else begin
            if (user_held.size() == 0) return 1'b0;
            idx   = $urandom_range(user_held.size() - 1);
            frame = user_held[idx];
            user_held.delete(idx);
         end
         return 1'b1;
      endfunction

      task log_mismatch(string msg);
         errors++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_response(logic [FRAME_W-1:0] frame, logic [1:0] status,
                          logic [COUNT_W-1:0] kern_free, logic [COUNT_W-1:0] user_free);
         page_result_type want;
         if (pending.size() == 0) begin
            log_mismatch("response beat with no request outstanding");
            return;
         end
         want = pending.pop_front();
         if (frame !== want.frame)
            log_mismatch($sformatf("alloc_frame %0h, predicted %0h", frame, want.frame));
         if (status !== want.status)
            log_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
         if (kern_free !== want.kern_free)
            log_mismatch($sformatf("kernel_free %0d, predicted %0d", kern_free, want.kern_free));
         if (user_free !== want.user_free)
            log_mismatch($sformatf("user_free %0d, predicted %0d", user_free, want.user_free));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_type = REQ_ALLOC;
   logic               req_region = REGION_USER;
   logic [FRAME_W-1:0] req_page_frame = '0;
   logic               rsp_valid;
   logic [FRAME_W-1:0] rsp_alloc_frame;
   logic [1:0]         rsp_status;
   logic [COUNT_W-1:0] rsp_kernel_free;
   logic [COUNT_W-1:0] rsp_user_free;

   page_alloc_scoreboard ledger = new();
   int sent = 0;

   two_region_page_free_list_allocator_core #(
      .BASE_FRAME(BASE_FRAME),
      .KERNEL_PAGES(KERNEL_PAGES),
      .USER_PAGES(USER_PAGES)
   ) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            ledger.check_response(rsp_alloc_frame, rsp_status, rsp_kernel_free, rsp_user_free);
         if (start && !busy)
            ledger.note_request(req_type, req_region, req_page_frame);
      end
   end

   // One request beat; start stays high afterwards unless the next call idles.
   task automatic send_request(logic kind, logic rgn, logic [FRAME_W-1:0] frame);
      while ((sent < 500 || sent >= 800) && $urandom_range(99) < 12) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_type       = kind;
      req_region     = rgn;
      req_page_frame = frame;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
      sent++;
   endtask

   task automatic alloc_page(logic rgn);
      send_request(REQ_ALLOC, rgn, FRAME_W'($urandom));
   endtask

   task automatic free_page(logic rgn);
      logic [FRAME_W-1:0] frame;
      if (!ledger.take_held(rgn, frame)) begin
         if (rgn == REGION_KERNEL)
            frame = FRAME_W'(KERN_FIRST + $urandom_range(KERNEL_PAGES - 1));
         else
            frame = FRAME_W'(USER_FIRST + $urandom_range(USER_PAGES - 1));
      end
      send_request(REQ_FREE, rgn, frame);
   endtask

   task automatic noise_request();
      logic [FRAME_W-1:0] frame;
      case ($urandom_range(5)) inside
         0, 1: frame = FRAME_W'($urandom);
         2: begin
            case ($urandom_range(5))
               0: frame = FRAME_W'(KERN_FIRST - 1);
               1: frame = FRAME_W'(KERN_FIRST);
               2: frame = FRAME_W'(USER_FIRST - 1);
               3: frame = FRAME_W'(USER_FIRST);
               4: frame = FRAME_W'(USER_END - 1);
               default: frame = FRAME_W'(USER_END);
            endcase
         end
         3: frame = $urandom_range(1) ? '1 : '0;
         default: frame = FRAME_W'(KERN_FIRST + $urandom_range(KERNEL_PAGES + USER_PAGES - 1));
      endcase
      send_request($urandom_range(1) ? REQ_FREE : REQ_ALLOC,
                   $urandom_range(1) ? REGION_KERNEL : REGION_USER, frame);
   endtask

   task automatic drain_kernel();
      int guard;
      guard = 0;
      while (ledger.kern_count != 0 && guard < 1100) begin
         alloc_page(REGION_KERNEL);
         guard++;
      end
      repeat (3) alloc_page(REGION_KERNEL);
      free_page(REGION_KERNEL);
      alloc_page(REGION_KERNEL);
      alloc_page(REGION_KERNEL);
   endtask

   initial begin
      int  pick, n;
      logic rgn;
      bit  drained;
      drained = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: first pops, saturating double frees, every range edge.
      send_request(REQ_ALLOC, REGION_USER, '1);
      send_request(REQ_ALLOC, REGION_KERNEL, '0);
      send_request(REQ_FREE, REGION_KERNEL, FRAME_W'(KERN_FIRST));
      send_request(REQ_FREE, REGION_KERNEL, FRAME_W'(KERN_FIRST + 5));
      send_request(REQ_FREE, REGION_KERNEL, FRAME_W'(USER_FIRST - 1));
      send_request(REQ_FREE, REGION_KERNEL, FRAME_W'(USER_FIRST));
      send_request(REQ_FREE, REGION_KERNEL, FRAME_W'(KERN_FIRST - 1));
      send_request(REQ_FREE, REGION_USER, FRAME_W'(USER_FIRST - 1));
      send_request(REQ_FREE, REGION_USER, FRAME_W'(USER_END));
      send_request(REQ_FREE, REGION_USER, FRAME_W'(USER_END - 1));
      send_request(REQ_FREE, REGION_USER, FRAME_W'(USER_FIRST));
      send_request(REQ_FREE, REGION_KERNEL, '0);
      send_request(REQ_FREE, REGION_USER, '1);
      send_request(REQ_FREE, REGION_KERNEL, '1);
      send_request(REQ_FREE, REGION_USER, '0);
      send_request(REQ_ALLOC, REGION_KERNEL, '0);
      send_request(REQ_ALLOC, REGION_USER, '1);

      // Random runs of allocates and frees; the kernel list is emptied once.
      while (sent < ITEM_GOAL) begin
         if (!drained && sent >= 300) begin
            drain_kernel();
            drained = 1'b1;
         end
         pick = $urandom_range(99);
         rgn  = $urandom_range(1) ? REGION_KERNEL : REGION_USER;
         n    = $urandom_range(5, 60);
         repeat (n) begin
            if (pick >= 90 || $urandom_range(99) < 8) noise_request();
            else if (pick < 35) alloc_page(rgn);
            else if (pick < 65) free_page(rgn);
            else if ($urandom_range(1)) alloc_page($urandom_range(1) ? REGION_KERNEL : REGION_USER);
            else free_page($urandom_range(1) ? REGION_KERNEL : REGION_USER);
         end
      end
      start = 1'b0;

      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== two_region_page_free_list_allocator_core.f =====
design/tpfl_pkg.sv
design/two_region_page_free_list_allocator_core.sv
dv/tb.sv
